[rtl/sbli_pkg.sv]
// ----------------------------------------------------------------------------
// sbli_pkg: shared types and constants
// Sizes and the per-cell handoff structs.
// ----------------------------------------------------------------------------
package sbli_pkg;

    localparam int POINTS = 10;
    localparam int CNT_W  = $clog2(POINTS + 1);

    // Neighbor handoff from one cell to the next.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               valid;
    } cell_data_t;

    typedef struct packed {
        logic               ins;      // insert step: shift/place
        logic signed [15:0] key;
        logic signed [15:0] y;
    } cell_ctl_t;

endpackage

[rtl/sbli_cell.sv]
// ----------------------------------------------------------------------------
// sbli_cell: one breakpoint cell
// Holds one (x, y) entry; on an insert step it keeps, takes the new point,
// or takes its lower neighbor's entry, as an insertion sorter does.
// ----------------------------------------------------------------------------
module sbli_cell
    import sbli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  cell_data_t prev,
    input  logic       prev_gt,
    output cell_data_t cur,
    output logic       gt
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [15:0] x_reg;
    logic signed [15:0] x_next;
    logic signed [15:0] y_reg;
    logic signed [15:0] y_next;

    assign cur.x     = x_reg;
    assign cur.y     = y_reg;
    assign cur.valid = valid_reg;
    assign gt        = valid_reg && (x_reg > ctl.key);

    // The new point lands in the first cell holding a larger x, or in the
    // first empty cell when no stored x is larger.
    always_comb
    begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (ctl.ins)
        begin
            if (prev_gt)
            begin
                valid_next = prev.valid;
                x_next     = prev.x;
                y_next     = prev.y;
            end
            else if (gt || (!valid_reg && prev.valid))
            begin
                valid_next = 1'b1;
                x_next     = ctl.key;
                y_next     = ctl.y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

[rtl/sbli_div.sv]
// ----------------------------------------------------------------------------
// sbli_div: sequential signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sbli_div
    import sbli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [33:0] num,
    input  logic        [16:0] den,
    output logic               done,
    output logic signed [34:0] quo
);

    logic [33:0] mag_reg, mag_next;
    logic [33:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    assign trial = {rem_reg, mag_reg[33]} - {1'b0, den_reg};

    always_comb
    begin
        mag_next  = mag_reg << 1;
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (run_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                q_next   = {q_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], mag_reg[33]};
                q_next   = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd34;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mag_reg <= num[33] ? 34'(-num) : 34'(num);
            neg_reg <= num[33];
            den_reg <= den;
            q_reg   <= 34'd0;
            rem_reg <= 17'd0;
        end
        else
        begin
            mag_reg <= mag_next;
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

[rtl/sorted_breakpoint_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// sorted_breakpoint_linear_interpolator: sorted breakpoint table with lerp
// A row of cells keeps the points sorted; queries scan the row and, between two points, divide.
// ----------------------------------------------------------------------------
// Flow: an insert passes through S_INS and S_OUT (S_OUT alone when the table is
// full); a query that clamps or finds the table empty ends its scan in S_OUT; an
// interpolated query runs the scan steps, multiply, divider load and divide first.
// One word at a time: busy is high until done, the next word is taken at the
// edge that ends the done cycle. Reset clears the count and cell valid bits;
// table data is not reset. Results are strobed one cycle and cannot be stalled.
module sorted_breakpoint_linear_interpolator
    import sbli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    output logic               done,
    output logic signed [15:0] result,
    output logic               accepted,
    output logic        [3:0]  points_held
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic signed [15:0] key_reg, ynew_reg;
    logic signed [15:0] res_reg;
    logic               ok_reg, done_reg;
    logic signed [15:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [33:0] prod_reg;
    logic [16:0]        span_reg;
    logic               div_go;
    logic               div_done;
    logic signed [34:0] div_q;

    cell_ctl_t  ctl;
    cell_data_t cur [POINTS];
    logic       gtv [POINTS];

    assign ctl.ins = (state_reg == S_INS);
    assign ctl.key = key_reg;
    assign ctl.y   = ynew_reg;

    genvar g;
    generate
        for (g = 0; g < POINTS; g++)
        begin : g_cell
            cell_data_t pv;
            logic       pg;
            if (g == 0)
            begin : g_first
                // The row head behaves as if an occupied cell sat before it.
                assign pv = '{x: 16'sd0, y: 16'sd0, valid: 1'b1};
                assign pg = 1'b0;
            end
            else
            begin : g_rest
                assign pv = cur[g-1];
                assign pg = gtv[g-1];
            end
            sbli_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .prev    (pv),
                .prev_gt (pg),
                .cur     (cur[g]),
                .gt      (gtv[g])
            );
        end
    endgenerate

    assign busy = (state_reg != S_IDLE);
    // The product is registered at the end of S_MUL, so the divider loads in S_DIV.
    assign div_go = (state_reg == S_DIV);

    sbli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (prod_reg),
        .den   (span_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    logic signed [35:0] sum;
    assign sum = 36'(y0_reg) + 36'(div_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg <= '0;
                        if (!cmd)
                        begin
                            if (count_reg < CNT_W'(POINTS))
                                state_reg <= S_INS;
                            else
                                state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_INS:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    if (count_reg == '0 || key_reg <= cur[0].x
                        || key_reg >= cur[count_reg-1'b1].x)
                        state_reg <= S_OUT;
                    else if (cur[idx_reg+1'b1].x >= key_reg)
                        state_reg <= S_MUL;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_MUL:  state_reg <= S_DIV;
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT: if (div_done) state_reg <= S_OUT;
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                key_reg  <= x_value;
                ynew_reg <= y_value;
                res_reg  <= 16'sd0;
                ok_reg   <= cmd || (count_reg < CNT_W'(POINTS));
            end
            S_SCAN:
            begin
                x0_reg <= cur[idx_reg].x;
                y0_reg <= cur[idx_reg].y;
                x1_reg <= cur[idx_reg+1'b1].x;
                y1_reg <= cur[idx_reg+1'b1].y;
                if (count_reg == '0)
                    res_reg <= 16'sd0;
                else if (key_reg <= cur[0].x)
                    res_reg <= cur[0].y;
                else if (key_reg >= cur[count_reg-1'b1].x)
                    res_reg <= cur[count_reg-1'b1].y;
            end
            S_MUL:
            begin
                prod_reg <= 34'(17'(y1_reg) - 17'(y0_reg)) *
                            34'(17'(key_reg) - 17'(x0_reg));
                span_reg <= 17'(17'(x1_reg) - 17'(x0_reg));
            end
            S_WAIT:
            begin
                if (div_done)
                    res_reg <= (sum > 36'sd32767) ? 16'sd32767 :
                               (sum < -36'sd32768) ? -16'sd32768 : sum[15:0];
            end
            default: ;
        endcase
    end

    assign done        = done_reg;
    assign result      = res_reg;
    assign accepted    = ok_reg;
    assign points_held = count_reg[3:0];

`ifndef SYNTH
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POINTS)) else $error("count overflow");
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not count");
`endif

endmodule
